/* hdl/rcfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfr_pkg
// Shared types and constants for the receive chunk frame reassembler.
// ----------------------------------------------------------------------------
package rcfr_pkg;

  // Default sizes
  localparam int CHUNK_PAYLOAD_BYTES_DEF = 64;
  localparam int MAX_FRAME_BYTES_DEF     = 1024;

  // Count of kept bytes per chunk, holds up to 127
  localparam int CNT_W = 7;

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ABORT  = 2'd1;
  localparam logic [1:0] KIND_PARITY = 2'd2;

  // Receive footer bit positions
  localparam int BIT_DV  = 21;
  localparam int BIT_SV  = 20;
  localparam int BIT_FD  = 15;
  localparam int BIT_EV  = 14;
  localparam int POS_EBO = 8;
  localparam int EBO_W   = 6;

  // Command from the classifier to the emitter
  typedef struct packed {
    logic [1:0]       kind;
    logic             ending;
    logic [CNT_W-1:0] cnt;
    logic [15:0]      fnum;
  } cmd_t;

endpackage
`default_nettype wire

/* hdl/rx_chunk_frame_reassembler_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rx_chunk_frame_reassembler_core
// Rebuilds received Ethernet frames from TC6 style data chunks.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: one transaction per payload byte (mode_i = 0) or per
//    receive footer (mode_i = 1). Accepted when in_valid_i is high and
//    in_stall_o is low.
//  - Output channel: one transaction per result (frame byte, abort or parity
//    halt), taken when out_valid_o is high and out_stall_i is low.
//  - Payload bytes: one per cycle unless stalled. A footer is classified in
//    the cycle it is accepted; its results pass the command queue, command
//    register, store read and output buffer, then one result per cycle
//    unless the output stalls; the chunk store's single read port sets it.
//  - Payload bytes of the next chunk are held off (in_stall_o) while the
//    store is being read out; footers only wait on a full command queue.
//  - After a footer with bad parity the block emits one halt result and
//    then accepts and drops every transaction until reset.
//  - Reset clears frame state, queue and output buffer; no clearing pass.
//  - A stall on the output holds the result and, once buffered and in-flight
//    results would fill the two-entry output buffer, pauses the store read-out.
// ----------------------------------------------------------------------------
module rx_chunk_frame_reassembler_core #(
  parameter int CHUNK_PAYLOAD_BYTES = rcfr_pkg::CHUNK_PAYLOAD_BYTES_DEF,
  parameter int MAX_FRAME_BYTES     = rcfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  payload_byte_i,
  input  wire logic [31:0] footer_word_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic             eof_o,
  output logic [15:0]      frame_number_o,
  output logic             last_of_run_o
);

  localparam int AW = $clog2(CHUNK_PAYLOAD_BYTES);

  rcfr_pkg::cmd_t push_cmd;
  rcfr_pkg::cmd_t head_cmd;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;
  logic           back_busy;
  logic           data_busy;
  logic           store_we;
  logic [AW-1:0]  store_addr;
  logic [7:0]     store_wdata;

  // store is in use while any command is queued or being emitted
  assign data_busy = back_busy || !q_empty;

  rcfr_front #(
    .CHUNK_PAYLOAD_BYTES (CHUNK_PAYLOAD_BYTES),
    .MAX_FRAME_BYTES     (MAX_FRAME_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .payload_byte_i (payload_byte_i),
    .footer_word_i  (footer_word_i),
    .q_full_i       (q_full),
    .data_busy_i    (data_busy),
    .push_o         (push),
    .cmd_o          (push_cmd),
    .store_we_o     (store_we),
    .store_addr_o   (store_addr),
    .store_wdata_o  (store_wdata)
  );

  rcfr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  rcfr_back #(
    .CHUNK_PAYLOAD_BYTES (CHUNK_PAYLOAD_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .store_we_i     (store_we),
    .store_addr_i   (store_addr),
    .store_wdata_i  (store_wdata),
    .cmd_i          (head_cmd),
    .q_empty_i      (q_empty),
    .q_pop_o        (pop),
    .busy_o         (back_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .eof_o          (eof_o),
    .frame_number_o (frame_number_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
`default_nettype wire

/* hdl/rcfr_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfr_cmd_fifo
// Two-entry command queue between the footer classifier and the emitter.
// ----------------------------------------------------------------------------
module rcfr_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rcfr_pkg::cmd_t cmd_i,
  input  wire logic           pop_i,
  output rcfr_pkg::cmd_t      cmd_o,
  output logic                empty_o,
  output logic                full_o
);

  rcfr_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

/* hdl/rcfr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfr_front
// Accepts payload bytes and footers, fills the chunk store and classifies
// each footer into an emit command. Holds the frame state.
// ----------------------------------------------------------------------------
module rcfr_front #(
  parameter int CHUNK_PAYLOAD_BYTES = rcfr_pkg::CHUNK_PAYLOAD_BYTES_DEF,
  parameter int MAX_FRAME_BYTES     = rcfr_pkg::MAX_FRAME_BYTES_DEF,
  localparam int AW = $clog2(CHUNK_PAYLOAD_BYTES),
  localparam int KW = $clog2(CHUNK_PAYLOAD_BYTES + 1),
  localparam int LW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           mode_i,
  input  wire logic [7:0]     payload_byte_i,
  input  wire logic [31:0]    footer_word_i,
  input  wire logic           q_full_i,
  input  wire logic           data_busy_i,
  output logic                push_o,
  output rcfr_pkg::cmd_t      cmd_o,
  output logic                store_we_o,
  output logic [AW-1:0]       store_addr_o,
  output logic [7:0]          store_wdata_o
);

  logic [KW-1:0] fill_q, fill_d;
  logic          inside_q, inside_d;
  logic [LW-1:0] len_q, len_d;
  logic [15:0]   fcnt_q, fcnt_d;
  logic          halted_q, halted_d;

  logic                  act;
  logic                  open_now;
  logic [LW-1:0]         len_base;
  logic [rcfr_pkg::CNT_W-1:0] ebo1;
  logic [KW-1:0]         keep;
  logic [LW:0]           len_sum;

  // Payload writes wait while the store is still being read out.
  assign in_stall_o = !halted_q && (mode_i ? q_full_i : data_busy_i);
  assign act        = in_valid_i && !in_stall_o && !halted_q;

  assign store_we_o    = act && !mode_i && (fill_q < KW'(CHUNK_PAYLOAD_BYTES));
  assign store_addr_o  = fill_q[AW-1:0];
  assign store_wdata_o = payload_byte_i;

  always_comb begin
    fill_d   = fill_q;
    inside_d = inside_q;
    len_d    = len_q;
    fcnt_d   = fcnt_q;
    halted_d = halted_q;
    push_o   = 1'b0;
    cmd_o.kind   = rcfr_pkg::KIND_ABORT;
    cmd_o.ending = 1'b0;
    cmd_o.cnt    = rcfr_pkg::CNT_W'(1);
    cmd_o.fnum   = fcnt_q;

    open_now = inside_q || footer_word_i[rcfr_pkg::BIT_SV];
    len_base = footer_word_i[rcfr_pkg::BIT_SV] ? '0 : len_q;
    ebo1     = rcfr_pkg::CNT_W'(footer_word_i[rcfr_pkg::POS_EBO +: rcfr_pkg::EBO_W]) +
               rcfr_pkg::CNT_W'(1);
    if (!footer_word_i[rcfr_pkg::BIT_EV] ||
        ebo1 > rcfr_pkg::CNT_W'(CHUNK_PAYLOAD_BYTES)) begin
      keep = KW'(CHUNK_PAYLOAD_BYTES);
    end else begin
      keep = KW'(ebo1);
    end
    len_sum = {1'b0, len_base} + (LW+1)'(keep);

    if (store_we_o) begin
      fill_d = fill_q + KW'(1);
    end

    if (act && mode_i) begin
      fill_d = '0;
      if (!(^footer_word_i)) begin
        halted_d   = 1'b1;
        push_o     = 1'b1;
        cmd_o.kind = rcfr_pkg::KIND_PARITY;
      end else if (footer_word_i[rcfr_pkg::BIT_FD]) begin
        push_o   = inside_q;
        inside_d = 1'b0;
        len_d    = '0;
      end else if (footer_word_i[rcfr_pkg::BIT_DV]) begin
        if (footer_word_i[rcfr_pkg::BIT_SV] && inside_q) begin
          // new start inside an open frame
          push_o   = 1'b1;
          inside_d = 1'b0;
          len_d    = '0;
        end else if (open_now) begin
          if (len_sum > (LW+1)'(MAX_FRAME_BYTES)) begin
            push_o   = 1'b1;
            inside_d = 1'b0;
            len_d    = '0;
          end else begin
            push_o       = 1'b1;
            cmd_o.kind   = rcfr_pkg::KIND_DATA;
            cmd_o.ending = footer_word_i[rcfr_pkg::BIT_EV];
            cmd_o.cnt    = rcfr_pkg::CNT_W'(keep);
            if (footer_word_i[rcfr_pkg::BIT_EV]) begin
              fcnt_d   = fcnt_q + 16'd1;
              inside_d = 1'b0;
              len_d    = '0;
            end else begin
              inside_d = 1'b1;
              len_d    = len_sum[LW-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      inside_q <= 1'b0;
      len_q    <= '0;
      fcnt_q   <= 16'd0;
      halted_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      inside_q <= inside_d;
      len_q    <= len_d;
      fcnt_q   <= fcnt_d;
      halted_q <= halted_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/rcfr_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfr_back
// Holds the chunk store, takes commands from the queue and emits results,
// one per cycle while the output is not stalled, through a two-entry output buffer.
// ----------------------------------------------------------------------------
module rcfr_back #(
  parameter int CHUNK_PAYLOAD_BYTES = rcfr_pkg::CHUNK_PAYLOAD_BYTES_DEF,
  localparam int AW = $clog2(CHUNK_PAYLOAD_BYTES)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           store_we_i,
  input  wire logic [AW-1:0]  store_addr_i,
  input  wire logic [7:0]     store_wdata_i,
  input  wire rcfr_pkg::cmd_t cmd_i,
  input  wire logic           q_empty_i,
  output logic                q_pop_o,
  output logic                busy_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          data_byte_o,
  output logic                eof_o,
  output logic [15:0]         frame_number_o,
  output logic                last_of_run_o
);

  logic [7:0] store_q [CHUNK_PAYLOAD_BYTES];
  logic [7:0] rdata_q;

  rcfr_pkg::cmd_t             cur_q;
  logic                       busy_q;
  logic [rcfr_pkg::CNT_W-1:0] idx_q;

  // read stage
  logic        pend_q;
  logic [1:0]  pend_kind_q;
  logic        pend_end_q;
  logic        pend_last_q;
  logic [15:0] pend_fnum_q;

  // output buffer
  logic [1:0]  ob_kind_q  [2];
  logic [7:0]  ob_data_q  [2];
  logic        ob_end_q   [2];
  logic [15:0] ob_fnum_q  [2];
  logic        ob_last_q  [2];
  logic        ob_wr_q, ob_rd_q;
  logic [1:0]  ob_cnt_q, ob_cnt_d;

  logic pop_out;
  logic credit;
  logic issue;
  logic last_el;

  assign busy_o      = busy_q;
  assign out_valid_o = (ob_cnt_q != 2'd0);
  assign pop_out     = out_valid_o && !out_stall_i;
  // room for one more read given what is buffered and in flight
  assign credit  = (ob_cnt_q + {1'b0, pend_q}) <= (2'd1 + {1'b0, pop_out});
  assign issue   = busy_q && credit;
  assign last_el = ((idx_q + rcfr_pkg::CNT_W'(1)) == cur_q.cnt);
  assign q_pop_o = !busy_q && !q_empty_i;

  assign kind_o         = ob_kind_q[ob_rd_q];
  assign data_byte_o    = ob_data_q[ob_rd_q];
  assign eof_o          = ob_end_q[ob_rd_q];
  assign frame_number_o = ob_fnum_q[ob_rd_q];
  assign last_of_run_o  = ob_last_q[ob_rd_q];

  always_comb begin
    ob_cnt_d = ob_cnt_q;
    if (pend_q && !pop_out) begin
      ob_cnt_d = ob_cnt_q + 2'd1;
    end else if (pop_out && !pend_q) begin
      ob_cnt_d = ob_cnt_q - 2'd1;
    end
  end

  // chunk store
  always_ff @(posedge clk_i) begin
    if (store_we_i) begin
      store_q[store_addr_i] <= store_wdata_i;
    end
    if (issue) begin
      rdata_q <= store_q[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      pend_q   <= issue;
      ob_cnt_q <= ob_cnt_d;
      if (q_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (issue) begin
        idx_q <= idx_q + rcfr_pkg::CNT_W'(1);
        if (last_el) begin
          busy_q <= 1'b0;
        end
      end
      if (pend_q) begin
        ob_wr_q <= ~ob_wr_q;
      end
      if (pop_out) begin
        ob_rd_q <= ~ob_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= cmd_i;
    end
    if (issue) begin
      pend_kind_q <= cur_q.kind;
      pend_end_q  <= cur_q.ending && last_el && (cur_q.kind == rcfr_pkg::KIND_DATA);
      pend_last_q <= last_el;
      pend_fnum_q <= cur_q.fnum;
    end
    if (pend_q) begin
      ob_kind_q[ob_wr_q] <= pend_kind_q;
      ob_data_q[ob_wr_q] <= (pend_kind_q == rcfr_pkg::KIND_DATA) ? rdata_q : 8'd0;
      ob_end_q[ob_wr_q]  <= pend_end_q;
      ob_fnum_q[ob_wr_q] <= pend_fnum_q;
      ob_last_q[ob_wr_q] <= pend_last_q;
    end
  end

endmodule
`default_nettype wire

/* hdl/rcfr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfr_checker
// Port-level checks on the result channel of the reassembler.
// ----------------------------------------------------------------------------
module rcfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  kind_o,
  input wire logic [7:0]  data_byte_o,
  input wire logic        eof_o,
  input wire logic [15:0] frame_number_o,
  input wire logic        last_of_run_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(kind_o) && $stable(data_byte_o) &&
      $stable(eof_o) && $stable(frame_number_o) && $stable(last_of_run_o))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == rcfr_pkg::KIND_DATA) || (kind_o == rcfr_pkg::KIND_ABORT) ||
      (kind_o == rcfr_pkg::KIND_PARITY))
    else $error("illegal result kind");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != rcfr_pkg::KIND_DATA) |->
      (data_byte_o == 8'd0) && last_of_run_o && !eof_o)
    else $error("abort or halt result malformed");

  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && eof_o |-> last_of_run_o && (kind_o == rcfr_pkg::KIND_DATA))
    else $error("frame end not on last data byte of run");

endmodule

bind rx_chunk_frame_reassembler_core rcfr_checker u_rcfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .data_byte_o    (data_byte_o),
  .eof_o          (eof_o),
  .frame_number_o (frame_number_o),
  .last_of_run_o  (last_of_run_o)
);
`default_nettype wire

/* dv/tb_rx_chunk_frame_reassembler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rx_chunk_frame_reassembler_core
// Self-checking bench for the receive chunk frame reassembler. A queue of
// payload and footer transactions feeds a clocked driver; every accepted
// transaction is run through a behavioural reassembly model that queues the
// frame bytes, aborts and halt results it must cause. A clocked monitor
// checks each result, field by field, against the oldest queued one.
// ----------------------------------------------------------------------------
module tb_rx_chunk_frame_reassembler_core;

  localparam int CHUNK_BYTES  = rcfr_pkg::CHUNK_PAYLOAD_BYTES_DEF;
  localparam int MAX_FRAME    = rcfr_pkg::MAX_FRAME_BYTES_DEF;
  localparam int RANDOM_ITEMS = 170;
  localparam int IDLE_PCT     = 18;
  localparam int MAX_REPORTS  = 40;
  // idle-free window, in clock cycles after start
  localparam int QUIET_FROM   = 600;
  localparam int QUIET_TO     = 1800;

  localparam logic MODE_PAYLOAD = 1'b0;
  localparam logic MODE_FOOTER  = 1'b1;

  // one input transaction
  typedef struct packed {
    logic        mode;
    logic [7:0]  pbyte;
    logic [31:0] fword;
  } rx_txn_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        fend;
    logic [15:0] fnum;
    logic        last;
  } rx_result_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        mode      = MODE_PAYLOAD;
  logic [7:0]  pbyte     = 8'h00;
  logic [31:0] fword     = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        eof;
  logic [15:0] frame_number;
  logic        last_of_run;

  rx_txn_t    pending_txns[$];
  rx_result_t expected_results[$];
  rx_txn_t    cur_txn;
  rx_result_t want_res;
  rx_result_t got_res;
  int         total_txns = 0;
  int         accepted   = 0;
  int         errors     = 0;
  int         cycle      = 0;
  logic       quiet;

  // reassembly model state
  logic [7:0]  chunk_mem [CHUNK_BYTES];
  int          fill_cnt  = 0;
  bit          frm_open  = 1'b0;
  int          frame_len = 0;
  logic [15:0] frame_cnt = 16'h0;
  bit          halted    = 1'b0;

  rx_chunk_frame_reassembler_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .payload_byte_i (pbyte),
    .footer_word_i  (fword),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .data_byte_o    (data_byte),
    .eof_o          (eof),
    .frame_number_o (frame_number),
    .last_of_run_o  (last_of_run)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
  end

  assign quiet = (cycle >= QUIET_FROM) && (cycle < QUIET_TO);

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99, 0) < IDLE_PCT);
  endfunction

  // --------------------------------------------------------------------------
  // Reassembly model
  // --------------------------------------------------------------------------
  function automatic void queue_result(logic [1:0] k, logic [7:0] d, logic fe,
                                       logic lr);
    rx_result_t r;
    r.kind = k;
    r.data = d;
    r.fend = fe;
    r.fnum = frame_cnt;
    r.last = lr;
    expected_results.push_back(r);
  endfunction

  // abandon the open frame with a single abort result
  function automatic void drop_frame();
    frm_open  = 1'b0;
    frame_len = 0;
    queue_result(rcfr_pkg::KIND_ABORT, 8'h00, 1'b0, 1'b1);
  endfunction

  function automatic void reassemble(rx_txn_t t);
    int          keep;
    bit          ending;
    logic [31:0] f;
    ending = 1'b0;
    f      = t.fword;
    if (halted) return;
    if (t.mode == MODE_PAYLOAD) begin
      // bytes past the chunk size fall on the floor
      if (fill_cnt < CHUNK_BYTES) begin
        chunk_mem[fill_cnt] = t.pbyte;
        fill_cnt++;
      end
      return;
    end
    fill_cnt = 0;
    // odd parity over the whole footer, else halt for good
    if (^f == 1'b0) begin
      halted = 1'b1;
      queue_result(rcfr_pkg::KIND_PARITY, 8'h00, 1'b0, 1'b1);
      return;
    end
    if (f[rcfr_pkg::BIT_FD]) begin
      if (frm_open) drop_frame();
      else frame_len = 0;
      return;
    end
    if (!f[rcfr_pkg::BIT_DV]) return;
    if (f[rcfr_pkg::BIT_SV]) begin
      // a start inside a frame kills the frame and the new chunk as well
      if (frm_open) begin
        drop_frame();
        return;
      end
      frm_open  = 1'b1;
      frame_len = 0;
    end
    if (!frm_open) return;
    if (f[rcfr_pkg::BIT_EV]) begin
      keep = int'(f[rcfr_pkg::POS_EBO +: rcfr_pkg::EBO_W]) + 1;
      if (keep > CHUNK_BYTES) keep = CHUNK_BYTES;
      ending = 1'b1;
    end else begin
      keep = CHUNK_BYTES;
    end
    if (frame_len + keep > MAX_FRAME) begin
      drop_frame();
      return;
    end
    for (int i = 0; i < keep; i++) begin
      queue_result(rcfr_pkg::KIND_DATA, chunk_mem[i], ending && (i == keep - 1),
                   i == keep - 1);
    end
    if (ending) begin
      frame_cnt = frame_cnt + 16'd1;
      frm_open  = 1'b0;
      frame_len = 0;
    end else begin
      frame_len += keep;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // footer with the given flags, random spare bits, parity forced good
  function automatic logic [31:0] good_footer(bit dv, bit sv, bit fd, bit ev,
                                              logic [5:0] ebo);
    logic [31:0] w;
    w                  = $urandom;
    w[rcfr_pkg::BIT_DV] = dv;
    w[rcfr_pkg::BIT_SV] = sv;
    w[rcfr_pkg::BIT_FD] = fd;
    w[rcfr_pkg::BIT_EV] = ev;
    w[rcfr_pkg::POS_EBO +: rcfr_pkg::EBO_W] = ebo;
    if (^w == 1'b0) w[0] = ~w[0];
    return w;
  endfunction

  task automatic add_byte(logic [7:0] b);
    rx_txn_t t;
    t.mode  = MODE_PAYLOAD;
    t.pbyte = b;
    t.fword = $urandom;
    pending_txns.push_back(t);
  endtask

  task automatic add_footer(logic [31:0] w);
    rx_txn_t t;
    t.mode  = MODE_FOOTER;
    t.pbyte = 8'($urandom);
    t.fword = w;
    pending_txns.push_back(t);
  endtask

  task automatic add_chunk(int n, logic [31:0] w);
    for (int i = 0; i < n; i++) add_byte(8'($urandom));
    add_footer(w);
  endtask

  // mostly short chunks; now and then a near-full, full or over-full one
  function automatic int chunk_len(bit long_frame);
    if (long_frame) return $urandom_range(2, 0);
    if ($urandom_range(99, 0) < 5) return $urandom_range(CHUNK_BYTES + 2, CHUNK_BYTES - 4);
    return $urandom_range(6, 0);
  endfunction

  // well-formed frame; long ones sit around the frame size limit
  task automatic random_frame();
    int conts;
    bit long_frame;
    long_frame = $urandom_range(99, 0) < 25;
    conts      = long_frame ? $urandom_range(16, 13) : $urandom_range(3, 0);
    if (conts == 0 && $urandom_range(1, 0)) begin
      add_chunk(chunk_len(1'b0), good_footer(1, 1, 0, 1, 6'($urandom)));
      return;
    end
    add_chunk(chunk_len(long_frame), good_footer(1, 1, 0, 0, 6'($urandom)));
    for (int i = 0; i < conts; i++) begin
      if ($urandom_range(9, 0) == 0)
        add_chunk(chunk_len(long_frame),
                  good_footer(0, 1'($urandom), 0, 1'($urandom), 6'($urandom)));
      add_chunk(chunk_len(long_frame), good_footer(1, 0, 0, 0, 6'($urandom)));
    end
    add_chunk(chunk_len(long_frame), good_footer(1, 0, 0, 1, 6'($urandom)));
  endtask

  // stray footers: broken sequences, drops, starts and ends out of place
  task automatic random_noise();
    add_chunk(chunk_len(1'b0),
              good_footer($urandom_range(99, 0) < 80, 1'($urandom),
                          $urandom_range(99, 0) < 15, 1'($urandom), 6'($urandom)));
  endtask

  // --------------------------------------------------------------------------
  // Driver: holds the payload while stalled, idles at random otherwise
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reassemble(cur_txn);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_txns.size() > 0 && !idle_now()) begin
          cur_txn = pending_txns.pop_front();
          in_valid <= 1'b1;
          mode     <= cur_txn.mode;
          pbyte    <= cur_txn.pbyte;
          fword    <= cur_txn.fword;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_now();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_res.kind = kind;
      got_res.data = data_byte;
      got_res.fend = eof;
      got_res.fnum = frame_number;
      got_res.last = last_of_run;
      if (expected_results.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: expected none, got kind=%0d data=%02h end=%0d fnum=%0d last=%0d",
                   $time, got_res.kind, got_res.data, got_res.fend, got_res.fnum,
                   got_res.last);
        errors++;
      end else begin
        want_res = expected_results.pop_front();
        if (got_res.kind !== want_res.kind || got_res.data !== want_res.data ||
            got_res.fend !== want_res.fend || got_res.fnum !== want_res.fnum ||
            got_res.last !== want_res.last) begin
          if (errors < MAX_REPORTS)
            $display("%0t: mismatch expected kind=%0d data=%02h end=%0d fnum=%0d last=%0d, got kind=%0d data=%02h end=%0d fnum=%0d last=%0d",
                     $time, want_res.kind, want_res.data, want_res.fend, want_res.fnum,
                     want_res.last, got_res.kind, got_res.data, got_res.fend,
                     got_res.fnum, got_res.last);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int start_size;
    int spare;
    foreach (chunk_mem[i]) chunk_mem[i] = 8'h00;

    // Fill the whole chunk store first, with extreme bytes and two bytes past
    // the chunk size; the footer is not valid so nothing comes out. After
    // this no kept position can read a store entry that was never written.
    add_byte(8'h00);
    add_byte(8'hFF);
    for (int i = 0; i < CHUNK_BYTES; i++) add_byte(8'($urandom));
    add_footer(good_footer(0, 0, 0, 0, 6'd0));
    // start and end in one short chunk, one byte kept
    add_chunk(1, good_footer(1, 1, 0, 1, 6'd0));
    // open frame, not-valid chunk inside it, end with all bytes kept
    add_chunk(3, good_footer(1, 1, 0, 0, 6'($urandom)));
    add_chunk(0, good_footer(0, 0, 0, 0, 6'($urandom)));
    add_chunk(2, good_footer(1, 0, 0, 1, 6'd63));
    // end with no frame open
    add_chunk(0, good_footer(1, 0, 0, 1, 6'd5));
    // start inside a frame
    add_chunk(1, good_footer(1, 1, 0, 0, 6'd0));
    add_chunk(1, good_footer(1, 1, 0, 1, 6'd2));
    // frame drop with a frame open (all flags set), then with none
    add_chunk(0, good_footer(1, 1, 0, 0, 6'd0));
    add_footer(32'hFFFF_FFFE);
    add_footer(good_footer(1, 0, 1, 0, 6'd0));
    // lowest good footer, and a continuation with no frame open
    add_footer(32'h0000_0001);
    add_chunk(2, good_footer(1, 0, 0, 0, 6'd0));

    start_size = pending_txns.size();
    while (pending_txns.size() - start_size < RANDOM_ITEMS) begin
      if ($urandom_range(99, 0) < 75) random_frame();
      else random_noise();
    end

    // parity failure halts the block; what follows must be dropped
    add_chunk(2, 32'h0000_0000);
    add_chunk(3, 32'hFFFF_FFFF);
    add_chunk(1, good_footer(1, 1, 0, 1, 6'd0));
    total_txns = pending_txns.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < total_txns) @(posedge clk);
    for (spare = 0; spare < 200000 && expected_results.size() > 0; spare++)
      @(posedge clk);
    // wait on to catch stray results
    repeat (100) @(posedge clk);
    if (expected_results.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("** rx_chunk_frame_reassembler_core: PASSED **");
    end else begin
      $display("** rx_chunk_frame_reassembler_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("** rx_chunk_frame_reassembler_core: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
hdl/rcfr_pkg.sv
hdl/rcfr_cmd_fifo.sv
hdl/rcfr_front.sv
hdl/rcfr_back.sv
hdl/rx_chunk_frame_reassembler_core.sv
hdl/rcfr_checker.sv
dv/tb_rx_chunk_frame_reassembler_core.sv
